// ===== rtl/core/ramod_pkg.sv =====
// ramod_pkg: shared widths, fixed-point constants and control structs of the modulator
`timescale 1ns / 1ps

package ramod_pkg;

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int CHAN_W   = 3;
    localparam int PHASE_W  = 32;
    localparam int GAIN_W   = 16;

    // clamped gain is one bit wider so that 1.0 fits
    localparam int GAINE_W  = GAIN_W + 1;
    localparam logic [GAINE_W-1:0] GAIN_ONE = GAINE_W'(32768);

    // shared multiplier operand and product widths
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // Q30 constants of the sine series
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // reciprocals for exact floor division of 32-bit values by 72, 42, 20 and 6
    localparam int S72 = 39;
    localparam int S42 = 38;
    localparam int S20 = 37;
    localparam int S6  = 35;
    localparam logic [32:0] RECIP_72 = 33'((64'd1 << S72) / 64'd72 + 64'd1);
    localparam logic [32:0] RECIP_42 = 33'((64'd1 << S42) / 64'd42 + 64'd1);
    localparam logic [32:0] RECIP_20 = 33'((64'd1 << S20) / 64'd20 + 64'd1);
    localparam logic [32:0] RECIP_6  = 33'((64'd1 << S6) / 64'd6 + 64'd1);

    // saturation limits
    localparam logic signed [27:0] SAMPLE_MAX = 28'sd8388607;
    localparam logic signed [27:0] SAMPLE_MIN = -28'sd8388608;

    // control from the top level to the arithmetic sequencer
    typedef struct packed {
        logic start;
        logic amp_mode;
    } calc_ctrl_t;

    // status back from the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } calc_stat_t;

endpackage

// ===== rtl/core/ramod_ram.sv =====
// ramod_ram: generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module ramod_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ramod_calc.sv =====
// ramod_calc: sine of the phase and the modulation product on one shared multiplier
`timescale 1ns / 1ps

module ramod_calc import ramod_pkg::*; #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  calc_ctrl_t                 ctrl,
    input  logic [PHASE_W-1:0]         phase,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [GAINE_W-1:0]         gain,
    output calc_stat_t                 stat,
    output logic signed [SAMPLE_W-1:0] result
);

    localparam int STB = SINE_TABLE_BITS;
    localparam int PW  = STB - 1;
    localparam logic [PW-1:0] SPAN = PW'(1) << (STB - 2);

    // sequencer steps; ST_SQ to ST_PROD do one multiply each
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQ    = 4'd1;
    localparam logic [3:0] ST_D72   = 4'd2;
    localparam logic [3:0] ST_T72   = 4'd3;
    localparam logic [3:0] ST_D42   = 4'd4;
    localparam logic [3:0] ST_T42   = 4'd5;
    localparam logic [3:0] ST_D20   = 4'd6;
    localparam logic [3:0] ST_T20   = 4'd7;
    localparam logic [3:0] ST_D6    = 4'd8;
    localparam logic [3:0] ST_T6    = 4'd9;
    localparam logic [3:0] ST_GAIN  = 4'd10;
    localparam logic [3:0] ST_PROD  = 4'd11;
    localparam logic [3:0] ST_ROUND = 4'd12;

    logic [3:0]                 st_reg;
    logic [3:0]                 st_next;
    logic                       done_reg;
    logic [PROD_W-1:0]          p_reg;
    logic [30:0]                x_reg;
    logic [31:0]                x2_reg;
    logic [1:0]                 quad_reg;
    logic signed [SAMPLE_W-1:0] result_reg;

    logic [STB-1:0]             idx;
    logic [PW-1:0]              pos;
    logic [30:0]                x_cur;
    logic [31:0]                n_cur;
    logic [30:0]                t72;
    logic [30:0]                t42;
    logic [30:0]                t20;
    logic [30:0]                t6;
    logic [17:0]                q_rnd;
    logic [14:0]                q_cap;
    logic signed [15:0]         sn;
    logic [16:0]                ofs;
    logic [32:0]                factor;
    logic signed [MUL_W-1:0]    a_mul;
    logic signed [MUL_W-1:0]    b_mul;
    logic signed [PROD_W-1:0]   prod;
    logic signed [55:0]         v;
    logic [55:0]                mag;
    logic [26:0]                r_mag;
    logic signed [27:0]         r_sgn;
    logic signed [SAMPLE_W-1:0] r_sat;

    // quadrant and mirrored position inside it
    assign idx = phase[PHASE_W-1 -: STB];
    assign pos = idx[STB-2] ? PW'(SPAN - {1'b0, idx[STB-3:0]}) : {1'b0, idx[STB-3:0]};

    // values taken from the last product
    assign x_cur = 31'(p_reg >> (STB - 2));
    assign n_cur = p_reg[61:30];
    assign t72   = ONE_Q30 - 31'(p_reg >> S72);
    assign t42   = ONE_Q30 - 31'(p_reg >> S42);
    assign t20   = ONE_Q30 - 31'(p_reg >> S20);
    assign t6    = ONE_Q30 - 31'(p_reg >> S6);

    // Q30 sine rounded half up to Q1.15, capped, signed by the half turn
    assign q_rnd = 18'(({1'b0, p_reg[61:30]} + 33'd16384) >> 15);
    assign q_cap = (q_rnd > 18'd32767) ? 15'd32767 : q_rnd[14:0];
    assign sn    = quad_reg[1] ? -$signed({1'b0, q_cap}) : $signed({1'b0, q_cap});

    // amplitude mode terms
    assign ofs    = 17'(17'd32768 + {sn[15], sn});
    assign factor = 33'h0_8000_0000 - {1'b0, p_reg[31:0]};

    // operand selection for the shared multiplier
    always_comb
    begin
        a_mul = '0;
        b_mul = '0;
        if (ctrl.start)
        begin
            a_mul = MUL_W'(pos);
            b_mul = MUL_W'(HALF_PI_Q30);
        end
        else
        begin
            case (st_reg)
                ST_SQ:
                begin
                    a_mul = MUL_W'(x_cur);
                    b_mul = MUL_W'(x_cur);
                end
                ST_D72:
                begin
                    a_mul = MUL_W'(n_cur);
                    b_mul = MUL_W'(RECIP_72);
                end
                ST_T72:
                begin
                    a_mul = MUL_W'(x2_reg);
                    b_mul = MUL_W'(t72);
                end
                ST_D42:
                begin
                    a_mul = MUL_W'(n_cur);
                    b_mul = MUL_W'(RECIP_42);
                end
                ST_T42:
                begin
                    a_mul = MUL_W'(x2_reg);
                    b_mul = MUL_W'(t42);
                end
                ST_D20:
                begin
                    a_mul = MUL_W'(n_cur);
                    b_mul = MUL_W'(RECIP_20);
                end
                ST_T20:
                begin
                    a_mul = MUL_W'(x2_reg);
                    b_mul = MUL_W'(t20);
                end
                ST_D6:
                begin
                    a_mul = MUL_W'(n_cur);
                    b_mul = MUL_W'(RECIP_6);
                end
                ST_T6:
                begin
                    a_mul = MUL_W'(x_reg);
                    b_mul = MUL_W'(t6);
                end
                ST_GAIN:
                begin
                    a_mul = MUL_W'(gain);
                    b_mul = ctrl.amp_mode ? MUL_W'(ofs) : {{(MUL_W-16){sn[15]}}, sn};
                end
                ST_PROD:
                begin
                    a_mul = {{(MUL_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
                    b_mul = ctrl.amp_mode ? MUL_W'(factor) : $signed(p_reg[MUL_W-1:0]);
                end
                default:
                begin
                    a_mul = '0;
                    b_mul = '0;
                end
            endcase
        end
    end

    assign prod = a_mul * b_mul;

    // round half away from zero, then saturate to the sample range
    assign v     = $signed(p_reg[55:0]);
    assign mag   = v[55] ? 56'(-v) : 56'(v);
    assign r_mag = ctrl.amp_mode ? 27'((57'(mag) + 57'h4000_0000) >> 31)
                                 : 27'((57'(mag) + 57'h2000_0000) >> 30);
    assign r_sgn = v[55] ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
    assign r_sat = (r_sgn > SAMPLE_MAX) ? SAMPLE_W'(SAMPLE_MAX) :
                   (r_sgn < SAMPLE_MIN) ? SAMPLE_W'(SAMPLE_MIN) : SAMPLE_W'(r_sgn);

    // step sequencing
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    st_next = ST_SQ;
                end
            end
            ST_ROUND:
            begin
                st_next = ST_IDLE;
            end
            default:
            begin
                st_next = st_reg + 4'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= (st_reg == ST_ROUND);
        end
    end

    // product and intermediate registers
    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(prod);
        if (ctrl.start)
        begin
            quad_reg <= idx[STB-1 -: 2];
        end
        if (st_reg == ST_SQ)
        begin
            x_reg <= x_cur;
        end
        if (st_reg == ST_D72)
        begin
            x2_reg <= n_cur;
        end
        if (st_reg == ST_ROUND)
        begin
            result_reg <= r_sat;
        end
    end

    assign stat.busy = (st_reg != ST_IDLE);
    assign stat.done = done_reg;
    assign result    = result_reg;

endmodule

// ===== rtl/core/ring_amplitude_modulator.sv =====
// ring_amplitude_modulator: per-channel sine ring / amplitude modulator top level
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  input   | in        | in_valid / in_ready  | sample_in, channel, phase_step, last_in_block
//  output  | out       | out_valid / out_ready| sample_out, out_channel, out_last, modulated
//  config  | in        | cfg_we               | cfg_index, cfg_data
//
//  A modulated item passes through one phase memory read, twelve dependent multiplies
//  on the single shared multiplier, and a rounding step before the next acceptance.
//  A pass-through item skips these steps.
//  Reset clears the configuration and marks every channel phase as zero through
//  per-channel valid bits; the phase memory itself is not swept.
//  A result waits in the output register while out_ready is low; the next item is
//  accepted meanwhile and stalls only when its own result is ready to be written.
`timescale 1ns / 1ps

module ring_amplitude_modulator import ramod_pkg::*; #(
    parameter int CHANNELS        = 8,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [CHAN_W-1:0]          channel,
    input  logic [PHASE_W-1:0]         phase_step,
    input  logic                       last_in_block,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic [CHAN_W-1:0]          out_channel,
    output logic                       out_last,
    output logic                       modulated,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [GAIN_W-1:0]          cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // register indexes
    localparam logic [0:0] REG_GAIN = 1'b0;
    localparam logic [0:0] REG_MODE = 1'b1;

    // control states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [GAIN_W-1:0]          gain_reg;
    logic                       amp_reg;
    logic [CHANNELS-1:0]        pvld_reg;
    logic                       pvld_rd_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [CHAN_W-1:0]          chan_reg;
    logic [AW-1:0]              addr_reg;
    logic [PHASE_W-1:0]         step_reg;
    logic                       last_reg;
    logic                       mod_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic [CHAN_W-1:0]          out_channel_reg;
    logic                       out_last_reg;
    logic                       modulated_reg;

    logic                       accept;
    logic                       chan_ok;
    logic                       do_mod;
    logic [AW-1:0]              in_addr;
    logic [GAINE_W-1:0]         gain_eff;
    logic                       rd_en;
    logic [PHASE_W-1:0]         rdata;
    logic [PHASE_W-1:0]         phase_cur;
    logic                       fin_go;
    logic                       wr_en;
    logic signed [SAMPLE_W-1:0] calc_result;
    calc_ctrl_t                 calc_ctrl;
    calc_stat_t                 calc_stat;

    // acceptance and the pass-through decision
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_addr  = AW'(channel);
    assign chan_ok  = (7'(channel) < 7'(CHANNELS));
    assign gain_eff = (gain_reg > GAIN_W'(GAIN_ONE)) ? GAIN_ONE : {1'b0, gain_reg};
    assign do_mod   = chan_ok && (phase_step != '0) && (gain_reg != '0);
    assign rd_en    = accept && do_mod;

    // a never-written channel reads as phase zero
    assign phase_cur = pvld_rd_reg ? rdata : '0;

    // result hand-off and phase write-back
    assign fin_go = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign wr_en  = fin_go && mod_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
            amp_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN: gain_reg <= cfg_data;
                REG_MODE: amp_reg  <= cfg_data[0];
                default:  ;
            endcase
        end
    end

    // control state machine
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = do_mod ? S_READ : S_FIN;
                end
            end
            S_READ:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (calc_stat.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // per-channel phase valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg <= '0;
        end
        else if (wr_en)
        begin
            pvld_reg[addr_reg] <= 1'b1;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample_in;
            chan_reg   <= channel;
            addr_reg   <= in_addr;
            step_reg   <= phase_step;
            last_reg   <= last_in_block;
            mod_reg    <= do_mod;
        end
        if (rd_en)
        begin
            pvld_rd_reg <= pvld_reg[in_addr];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            sample_out_reg  <= mod_reg ? calc_result : sample_reg;
            out_channel_reg <= chan_reg;
            out_last_reg    <= last_reg;
            modulated_reg   <= mod_reg;
        end
    end

    // phase memory
    ramod_ram #(
        .WIDTH(PHASE_W),
        .DEPTH(CHANNELS)
    ) u_phase_ram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(addr_reg),
        .wdata(phase_cur + step_reg),
        .re   (rd_en),
        .raddr(in_addr),
        .rdata(rdata)
    );

    // sine and product sequencer
    assign calc_ctrl.start    = (state_reg == S_READ);
    assign calc_ctrl.amp_mode = amp_reg;

    ramod_calc #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_calc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (calc_ctrl),
        .phase (phase_cur),
        .sample(sample_reg),
        .gain  (gain_eff),
        .stat  (calc_stat),
        .result(calc_result)
    );

    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign out_channel = out_channel_reg;
    assign out_last    = out_last_reg;
    assign modulated   = modulated_reg;

endmodule

// ===== rtl/core/ramod_chk.sv =====
// ramod_chk: port-level checker for the modulator and its bind
`timescale 1ns / 1ps

module ramod_chk import ramod_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic signed [SAMPLE_W-1:0] sample_in,
    input logic [CHAN_W-1:0]          channel,
    input logic [PHASE_W-1:0]         phase_step,
    input logic                       last_in_block,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] sample_out,
    input logic [CHAN_W-1:0]          out_channel,
    input logic                       out_last,
    input logic                       modulated,
    input logic                       cfg_we,
    input logic [0:0]                 cfg_index,
    input logic [GAIN_W-1:0]          cfg_data
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out)
            && $stable(out_channel) && $stable(out_last) && $stable(modulated))
        else $error("stalled output item changed");

    // one item in flight: no acceptance right after an acceptance
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // a new result only comes from an item in flight
    a_out_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("output item appeared with no item in flight");

    // only channels that have a phase accumulator are modulated
    a_mod_chan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && modulated |-> (7'(out_channel) < 7'(CHANNELS)))
        else $error("modulated item on a channel without a phase");

endmodule

bind ring_amplitude_modulator ramod_chk #(.CHANNELS(CHANNELS)) u_ramod_chk (.*);
